// ===== rtl/gga_pkg.sv =====
`default_nettype none

package gga_pkg;

	// field length limit default
	localparam int MAX_FIELD_LEN = 16;

	// widths of the fixed fields
	localparam int PHASE_W = 5;
	localparam int SKIP_W  = 2;
	localparam int CODE_W  = 3;
	localparam int INDEX_W = 4;
	localparam int BYTE_W  = 8;

	// parse phases
	localparam logic [PHASE_W-1:0] PH_HUNT    = 5'd0;
	localparam logic [PHASE_W-1:0] PH_TIME    = 5'd7;
	localparam logic [PHASE_W-1:0] PH_LAT     = 5'd8;
	localparam logic [PHASE_W-1:0] PH_NS      = 5'd9;
	localparam logic [PHASE_W-1:0] PH_SKIP_NS = 5'd10;
	localparam logic [PHASE_W-1:0] PH_LON     = 5'd11;
	localparam logic [PHASE_W-1:0] PH_EW      = 5'd12;
	localparam logic [PHASE_W-1:0] PH_SKIP_EW = 5'd13;
	localparam logic [PHASE_W-1:0] PH_SATS    = 5'd14;
	localparam logic [PHASE_W-1:0] PH_DOP     = 5'd15;
	localparam logic [PHASE_W-1:0] PH_ALT     = 5'd16;

	// field codes on the result
	localparam logic [CODE_W-1:0] FC_TIME = 3'd0;
	localparam logic [CODE_W-1:0] FC_LAT  = 3'd1;
	localparam logic [CODE_W-1:0] FC_NS   = 3'd2;
	localparam logic [CODE_W-1:0] FC_LON  = 3'd3;
	localparam logic [CODE_W-1:0] FC_EW   = 3'd4;
	localparam logic [CODE_W-1:0] FC_SATS = 3'd5;
	localparam logic [CODE_W-1:0] FC_DOP  = 3'd6;
	localparam logic [CODE_W-1:0] FC_ALT  = 3'd7;

	// skip lengths after the hemisphere characters
	localparam logic [SKIP_W-1:0] SKIP_AFTER_NS = 2'd2;
	localparam logic [SKIP_W-1:0] SKIP_AFTER_EW = 2'd3;

	// characters
	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
	localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
	localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
	localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2c;

	// control state other than the field position
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [SKIP_W-1:0]  skip;
	} ctrl_t;

	// one result transaction payload
	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [INDEX_W-1:0] index;
		logic [BYTE_W-1:0]  value;
		logic               done;
	} result_t;

	// expected header character for a header phase
	function automatic logic [BYTE_W-1:0] header_char(input logic [2:0] ph);
		logic [BYTE_W-1:0] c;
		case (ph)
			3'd0:    c = CH_DOLLAR;
			3'd1:    c = CH_G;
			3'd2:    c = CH_P;
			3'd3:    c = CH_G;
			3'd4:    c = CH_G;
			3'd5:    c = CH_A;
			3'd6:    c = CH_COMMA;
			default: c = CH_DOLLAR;
		endcase
		return c;
	endfunction

	// field code of a variable-length phase
	function automatic logic [CODE_W-1:0] field_code_of(input logic [PHASE_W-1:0] ph);
		logic [CODE_W-1:0] c;
		case (ph)
			PH_TIME: c = FC_TIME;
			PH_LAT:  c = FC_LAT;
			PH_LON:  c = FC_LON;
			PH_SATS: c = FC_SATS;
			PH_DOP:  c = FC_DOP;
			default: c = FC_ALT;
		endcase
		return c;
	endfunction

	// phase after a variable-length field
	function automatic logic [PHASE_W-1:0] next_phase_of(input logic [PHASE_W-1:0] ph);
		logic [PHASE_W-1:0] n;
		case (ph)
			PH_TIME: n = PH_LAT;
			PH_LAT:  n = PH_NS;
			PH_LON:  n = PH_EW;
			PH_SATS: n = PH_DOP;
			PH_DOP:  n = PH_ALT;
			default: n = PH_HUNT;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/gga_parse_step.sv =====
`default_nettype none

module gga_parse_step #(
	parameter int MAX_FIELD_LEN = gga_pkg::MAX_FIELD_LEN,
	parameter int POS_W         = $clog2(MAX_FIELD_LEN)
) (
	input  wire gga_pkg::ctrl_t                    ctrl,
	input  wire logic [POS_W-1:0]                  pos,
	input  wire logic [gga_pkg::BYTE_W-1:0]        rx_char,
	output gga_pkg::ctrl_t                         ctrl_nxt,
	output logic [POS_W-1:0]                       pos_nxt,
	output logic                                   produce,
	output gga_pkg::result_t                       res
);

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_FIELD_LEN - 1);

	logic [gga_pkg::PHASE_W-1:0] ph;
	logic [gga_pkg::PHASE_W-1:0] ph_inc;
	logic [4:0]                  pos_ext;

	// unused phase codes behave as hunting
	assign ph      = (ctrl.phase > gga_pkg::PH_ALT) ? gga_pkg::PH_HUNT : ctrl.phase;
	assign ph_inc  = gga_pkg::PHASE_W'(ph + 5'd1);
	assign pos_ext = 5'(pos);

	// one byte of the sentence: next phase, position and result
	always_comb begin
		ctrl_nxt  = ctrl;
		ctrl_nxt.phase = ph;
		pos_nxt   = pos;
		produce   = 1'b0;
		res.code  = gga_pkg::field_code_of(ph);
		res.index = pos_ext[gga_pkg::INDEX_W-1:0];
		res.value = rx_char;
		res.done  = 1'b0;
		if (ph < gga_pkg::PH_TIME) begin
			ctrl_nxt.phase = (rx_char == gga_pkg::header_char(ph[2:0])) ? ph_inc
				: gga_pkg::PH_HUNT;
			pos_nxt = '0;
		end else begin
			case (ph)
				gga_pkg::PH_NS, gga_pkg::PH_EW: begin
					produce        = 1'b1;
					res.code       = (ph == gga_pkg::PH_NS) ? gga_pkg::FC_NS : gga_pkg::FC_EW;
					res.index      = '0;
					ctrl_nxt.phase = ph_inc;
					ctrl_nxt.skip  = (ph == gga_pkg::PH_NS) ? gga_pkg::SKIP_AFTER_NS
						: gga_pkg::SKIP_AFTER_EW;
					pos_nxt        = '0;
				end
				gga_pkg::PH_SKIP_NS, gga_pkg::PH_SKIP_EW: begin
					if (ctrl.skip <= 2'd1) begin
						ctrl_nxt.skip  = '0;
						ctrl_nxt.phase = ph_inc;
						pos_nxt        = '0;
					end else begin
						ctrl_nxt.skip = ctrl.skip - 2'd1;
					end
				end
				default: begin
					// variable-length field, comma always closes it
					if (rx_char == gga_pkg::CH_COMMA) begin
						produce        = 1'b1;
						res.done       = (ph == gga_pkg::PH_ALT);
						ctrl_nxt.phase = gga_pkg::next_phase_of(ph);
						pos_nxt        = '0;
					end else if (pos < POS_LAST) begin
						produce = 1'b1;
						pos_nxt = pos + 1'b1;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gga_sentence_field_extractor.sv =====
// path: each byte is held in the input register, then its result is written into the result register
// throughput: one byte per cycle; the input register drains into the result
//   register whenever the result register is empty or being taken
// reset: arst_n clears the parse phase, skip count, field position and both
//   valid flags; the block then hunts for the header

`default_nettype none

module gga_sentence_field_extractor #(
	parameter int MAX_FIELD_LEN = gga_pkg::MAX_FIELD_LEN
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [gga_pkg::BYTE_W-1:0]     rx_byte,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [gga_pkg::CODE_W-1:0]          field_code,
	output logic [gga_pkg::INDEX_W-1:0]         char_index,
	output logic [gga_pkg::BYTE_W-1:0]          char_value,
	output logic                                record_done
);

	localparam int POS_W = $clog2(MAX_FIELD_LEN);

	logic                        valid_s1;
	logic [gga_pkg::BYTE_W-1:0]  byte_s1;
	gga_pkg::ctrl_t              ctrl_q;
	gga_pkg::ctrl_t              ctrl_nxt;
	logic [POS_W-1:0]            pos_q;
	logic [POS_W-1:0]            pos_nxt;
	logic                        produce;
	gga_pkg::result_t            res;
	gga_pkg::result_t            res_s2;
	logic                        advance;

	// stage one moves on when the result register can take its result
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	gga_parse_step #(
		.MAX_FIELD_LEN(MAX_FIELD_LEN),
		.POS_W(POS_W)
	) u_step (
		.ctrl(ctrl_q),
		.pos(pos_q),
		.rx_char(byte_s1),
		.ctrl_nxt(ctrl_nxt),
		.pos_nxt(pos_nxt),
		.produce(produce),
		.res(res)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '{phase: gga_pkg::PH_HUNT, skip: '0};
			pos_q  <= '0;
		end else if (advance) begin
			ctrl_q <= ctrl_nxt;
			pos_q  <= pos_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= produce;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			res_s2 <= res;
		end
	end

	assign field_code  = res_s2.code;
	assign char_index  = res_s2.index;
	assign char_value  = res_s2.value;
	assign record_done = res_s2.done;

endmodule

`default_nettype wire

// ===== rtl/gga_checker.sv =====
`default_nettype none

module gga_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic [gga_pkg::BYTE_W-1:0] rx_byte,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [gga_pkg::CODE_W-1:0] field_code,
	input wire logic [gga_pkg::INDEX_W-1:0] char_index,
	input wire logic [gga_pkg::BYTE_W-1:0] char_value,
	input wire logic                       record_done
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(field_code)
		&& $stable(char_index) && $stable(char_value) && $stable(record_done))
		else $error("result changed while stalled");

	// record end only on the altitude comma
	a_done_alt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_done |->
		field_code == gga_pkg::FC_ALT && char_value == gga_pkg::CH_COMMA)
		else $error("record end outside altitude comma");

	// hemisphere characters sit at index zero
	a_hemi_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (field_code == gga_pkg::FC_NS || field_code == gga_pkg::FC_EW)
		|-> char_index == '0)
		else $error("hemisphere character at nonzero index");

	// a new header must pass before the next result
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && record_done |=> !out_valid)
		else $error("result right after record end");

endmodule

bind gga_sentence_field_extractor gga_checker u_gga_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int FIELD_MAX = gga_pkg::MAX_FIELD_LEN;
	localparam int RANDOM_BYTES = 1050;
	localparam int MAX_SHOWN = 10;

	// header bytes in the order they are matched
	localparam logic [gga_pkg::BYTE_W-1:0] GGA_HEADER [7] = '{
		gga_pkg::CH_DOLLAR, gga_pkg::CH_G, gga_pkg::CH_P, gga_pkg::CH_G, gga_pkg::CH_G,
		gga_pkg::CH_A, gga_pkg::CH_COMMA
	};

	// how a directed row gets its expectation
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_RESULT,
		ROW_SILENT
	} row_kind_t;

	typedef struct packed {
		logic [gga_pkg::BYTE_W-1:0] rx;
		row_kind_t                  kind;
		gga_pkg::result_t           res;
	} stim_row_t;

	// directed sentence: extremes, empty fields, comma as ns, skips, broken header
	localparam int DIRECTED_ROWS = 27;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{gga_pkg::CH_DOLLAR, ROW_SILENT, '0},
		'{gga_pkg::CH_G,      ROW_SILENT, '0},
		'{gga_pkg::CH_P,      ROW_SILENT, '0},
		'{gga_pkg::CH_G,      ROW_SILENT, '0},
		'{gga_pkg::CH_G,      ROW_SILENT, '0},
		'{gga_pkg::CH_A,      ROW_SILENT, '0},
		'{gga_pkg::CH_COMMA,  ROW_SILENT, '0},
		'{8'h00,     ROW_RESULT, '{gga_pkg::FC_TIME, 4'd0, 8'h00, 1'b0}},
		'{8'hff,     ROW_RESULT, '{gga_pkg::FC_TIME, 4'd1, 8'hff, 1'b0}},
		'{gga_pkg::CH_COMMA,  ROW_RESULT,
			'{gga_pkg::FC_TIME, 4'd2, gga_pkg::CH_COMMA, 1'b0}},
		'{gga_pkg::CH_COMMA,  ROW_RESULT,
			'{gga_pkg::FC_LAT, 4'd0, gga_pkg::CH_COMMA, 1'b0}},
		'{gga_pkg::CH_COMMA,  ROW_RESULT,
			'{gga_pkg::FC_NS, 4'd0, gga_pkg::CH_COMMA, 1'b0}},
		'{8'hff,     ROW_SILENT, '0},
		'{8'h00,     ROW_SILENT, '0},
		'{8'h37,     ROW_PREDICT, '0},
		'{gga_pkg::CH_COMMA,  ROW_PREDICT, '0},
		'{8'h45,     ROW_PREDICT, '0},
		'{gga_pkg::CH_COMMA,  ROW_SILENT, '0},
		'{8'hff,     ROW_SILENT, '0},
		'{8'h00,     ROW_SILENT, '0},
		'{gga_pkg::CH_COMMA,  ROW_RESULT,
			'{gga_pkg::FC_SATS, 4'd0, gga_pkg::CH_COMMA, 1'b0}},
		'{8'h31,     ROW_PREDICT, '0},
		'{gga_pkg::CH_COMMA,  ROW_PREDICT, '0},
		'{gga_pkg::CH_COMMA,  ROW_RESULT,
			'{gga_pkg::FC_ALT, 4'd0, gga_pkg::CH_COMMA, 1'b1}},
		'{gga_pkg::CH_DOLLAR, ROW_SILENT, '0},
		'{gga_pkg::CH_DOLLAR, ROW_SILENT, '0},
		'{gga_pkg::CH_G,      ROW_SILENT, '0}
	};

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [gga_pkg::BYTE_W-1:0]    rx_byte = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [gga_pkg::CODE_W-1:0]    field_code;
	logic [gga_pkg::INDEX_W-1:0]   char_index;
	logic [gga_pkg::BYTE_W-1:0]    char_value;
	logic                          record_done;

	// tracked parser state
	logic [gga_pkg::PHASE_W-1:0]   trk_phase;
	logic [4:0]                    trk_pos;
	logic [gga_pkg::SKIP_W-1:0]    trk_skip;

	gga_pkg::result_t    expected_chars [$];
	int                  fail_count = 0;
	int                  bytes_sent = 0;
	int                  src_calm = 0;
	int                  sink_calm = 0;

	gga_sentence_field_extractor #(
		.MAX_FIELD_LEN(FIELD_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.field_code(field_code),
		.char_index(char_index),
		.char_value(char_value),
		.record_done(record_done)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// idle cycles before the next transaction, with occasional back-to-back stretches
	function automatic int draw_idle(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			calm = $urandom_range(8, 40);
		return $urandom_range(0, 12);
	endfunction

	// advance the tracked parser by one byte, returns 1 when a character is captured
	function automatic bit predict_capture(input logic [gga_pkg::BYTE_W-1:0] b,
		output gga_pkg::result_t r);
		logic [gga_pkg::PHASE_W-1:0] ph;
		ph = (trk_phase > gga_pkg::PH_ALT) ? gga_pkg::PH_HUNT : trk_phase;
		r = '0;

		// header match
		if (ph < gga_pkg::PH_TIME) begin
			trk_phase = (b == GGA_HEADER[ph[2:0]]) ? gga_pkg::PHASE_W'(ph + 1)
				: gga_pkg::PH_HUNT;
			trk_pos = '0;
			return 1'b0;
		end

		// single-character hemisphere fields
		if (ph == gga_pkg::PH_NS || ph == gga_pkg::PH_EW) begin
			r.code = (ph == gga_pkg::PH_NS) ? gga_pkg::FC_NS : gga_pkg::FC_EW;
			r.index = '0;
			r.value = b;
			r.done = 1'b0;
			trk_phase = gga_pkg::PHASE_W'(ph + 1);
			trk_skip = (ph == gga_pkg::PH_NS) ? gga_pkg::SKIP_AFTER_NS
				: gga_pkg::SKIP_AFTER_EW;
			trk_pos = '0;
			return 1'b1;
		end

		// dropped bytes after a hemisphere
		if (ph == gga_pkg::PH_SKIP_NS || ph == gga_pkg::PH_SKIP_EW) begin
			if (trk_skip <= 1) begin
				trk_skip = '0;
				trk_phase = gga_pkg::PHASE_W'(ph + 1);
				trk_pos = '0;
			end else begin
				trk_skip = trk_skip - 1'b1;
			end
			return 1'b0;
		end

		// variable-length field
		case (ph)
			gga_pkg::PH_TIME: r.code = gga_pkg::FC_TIME;
			gga_pkg::PH_LAT:  r.code = gga_pkg::FC_LAT;
			gga_pkg::PH_LON:  r.code = gga_pkg::FC_LON;
			gga_pkg::PH_SATS: r.code = gga_pkg::FC_SATS;
			gga_pkg::PH_DOP:  r.code = gga_pkg::FC_DOP;
			default:          r.code = gga_pkg::FC_ALT;
		endcase
		r.index = trk_pos[gga_pkg::INDEX_W-1:0];
		r.value = b;
		r.done = 1'b0;
		if (b == gga_pkg::CH_COMMA) begin
			r.done = (ph == gga_pkg::PH_ALT);
			case (ph)
				gga_pkg::PH_TIME: trk_phase = gga_pkg::PH_LAT;
				gga_pkg::PH_LAT:  trk_phase = gga_pkg::PH_NS;
				gga_pkg::PH_LON:  trk_phase = gga_pkg::PH_EW;
				gga_pkg::PH_SATS: trk_phase = gga_pkg::PH_DOP;
				gga_pkg::PH_DOP:  trk_phase = gga_pkg::PH_ALT;
				default:          trk_phase = gga_pkg::PH_HUNT;
			endcase
			trk_pos = '0;
			return 1'b1;
		end
		// overlong field, last slot kept for the comma
		if (trk_pos >= FIELD_MAX - 1)
			return 1'b0;
		trk_pos = trk_pos + 1'b1;
		return 1'b1;
	endfunction

	// present one byte and hold it until the transaction completes
	task automatic drive_byte(input logic [gga_pkg::BYTE_W-1:0] b);
		int gap;
		gap = draw_idle(src_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_byte(input logic [gga_pkg::BYTE_W-1:0] b);
		gga_pkg::result_t r;
		if (predict_capture(b, r))
			expected_chars.push_back(r);
		drive_byte(b);
	endtask

	// random non-comma characters then the closing comma
	task automatic send_field();
		int len;
		logic [gga_pkg::BYTE_W-1:0] c;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 20) : $urandom_range(0, 7);
		repeat (len) begin
			c = 8'($urandom_range(0, 255));
			if (c == gga_pkg::CH_COMMA)
				c = c ^ 8'h01;
			send_byte(c);
		end
		send_byte(gga_pkg::CH_COMMA);
	endtask

	// hemisphere byte, mostly a letter, sometimes anything
	task automatic send_hemi(input logic [gga_pkg::BYTE_W-1:0] a,
		input logic [gga_pkg::BYTE_W-1:0] z);
		logic [gga_pkg::BYTE_W-1:0] c;
		if ($urandom_range(0, 5) == 0)
			c = 8'($urandom_range(0, 255));
		else
			c = $urandom_range(0, 1) ? a : z;
		send_byte(c);
	endtask

	// skipped bytes, usually a comma first
	task automatic send_skip(input int n);
		send_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : gga_pkg::CH_COMMA);
		repeat (n - 1)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	// one sentence: noise, then the header and all fields, or sometimes a broken header alone
	task automatic send_sentence();
		int cut;
		repeat ($urandom_range(0, 3))
			send_byte(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 7) == 0) begin
			cut = $urandom_range(0, 6);
			for (int i = 0; i < cut; i++)
				send_byte(GGA_HEADER[i]);
			send_byte(8'($urandom_range(0, 255)));
			return;
		end
		foreach (GGA_HEADER[i])
			send_byte(GGA_HEADER[i]);
		send_field();
		send_field();
		send_hemi(8'h4e, 8'h53);
		send_skip(int'(gga_pkg::SKIP_AFTER_NS));
		send_field();
		send_hemi(8'h45, 8'h57);
		send_skip(int'(gga_pkg::SKIP_AFTER_EW));
		send_field();
		send_field();
		send_field();
	endtask

	// stimulus
	initial begin
		gga_pkg::result_t r;
		bit got;
		trk_phase = gga_pkg::PH_HUNT;
		trk_pos = '0;
		trk_skip = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			got = predict_capture(DIRECTED[i].rx, r);
			case (DIRECTED[i].kind)
				ROW_PREDICT: if (got) expected_chars.push_back(r);
				ROW_RESULT:  expected_chars.push_back(DIRECTED[i].res);
				default:     ;
			endcase
			drive_byte(DIRECTED[i].rx);
		end

		// random sentences
		while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES)
			send_sentence();
		in_valid <= 1'b0;

		// drain and let the pipeline settle
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0 && expected_chars.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// result sink and checker
	initial begin
		gga_pkg::result_t want;
		int stall;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = draw_idle(sink_calm);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (expected_chars.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_SHOWN)
					$display("unexpected transaction: code=%0d idx=%0d val=%02h done=%0b",
						field_code, char_index, char_value, record_done);
			end else begin
				want = expected_chars.pop_front();
				if (field_code !== want.code || char_index !== want.index ||
					char_value !== want.value || record_done !== want.done) begin
					fail_count++;
					if (fail_count <= MAX_SHOWN)
						$display("mismatch: want %0d/%0d/%02h/%0b got %0d/%0d/%02h/%0b",
							want.code, want.index, want.value, want.done,
							field_code, char_index, char_value, record_done);
				end
			end
		end
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
